>>> sv/time_ordered_event_queue_core_assert.svh
// Assertion macros shared by the event queue RTL.
`ifndef TIME_ORDERED_EVENT_QUEUE_CORE_ASSERT_SVH
`define TIME_ORDERED_EVENT_QUEUE_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define TOEQ_CHECK(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TOEQ_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/toeq_pkg.sv
// Types, codes and constants of the time-ordered event queue.
package toeq_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int TIME_W = 32;
    localparam int NAME_W = 8;
    localparam int TASK_W = 8;
    localparam int POS_W  = 8;
    localparam int OCC_W  = 5;

    // Command codes on the input channel
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_POP,
        OP_REMOVE,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [NAME_W-1:0] ev_name;
        logic [TASK_W-1:0] ev_task;
        logic              ev_break;
    } t_event;

    typedef struct packed {
        t_op              op;
        t_event           ev;
        logic [POS_W-1:0] position;
    } t_cmd_item;

    typedef struct packed {
        t_status          status;
        t_event           ev;
        logic [OCC_W-1:0] occupancy;
    } t_result;

endpackage

>>> sv/toeq_if.sv
// Valid/ready channel interfaces for commands and results.
interface toeq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [toeq_pkg::TIME_W-1:0] event_time;
    logic [toeq_pkg::NAME_W-1:0] event_name;
    logic [toeq_pkg::TASK_W-1:0] event_task;
    logic                        event_break;
    logic [toeq_pkg::POS_W-1:0]  position;

    modport source (output valid, cmd, event_time, event_name, event_task, event_break,
                    position, input ready);
    modport sink   (input valid, cmd, event_time, event_name, event_task, event_break,
                    position, output ready);
endinterface

interface toeq_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [toeq_pkg::TIME_W-1:0] out_time;
    logic [toeq_pkg::NAME_W-1:0] out_name;
    logic [toeq_pkg::TASK_W-1:0] out_task;
    logic                        out_break;
    logic [toeq_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, status, out_time, out_name, out_task, out_break,
                    occupancy, input ready);
    modport sink   (input valid, status, out_time, out_name, out_task, out_break,
                    occupancy, output ready);
endinterface

>>> sv/toeq_front.sv
// Command front end: decodes accepted items into a two-entry queue.
module toeq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    toeq_cmd_if.sink             i_cmd,
    output logic                 o_q_valid,
    output toeq_pkg::t_cmd_item  o_q_item,
    input  logic                 i_q_pop
);
    import toeq_pkg::*;

    t_cmd_item  r_q [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    t_cmd_item  dec_item;
    logic       push;

    always_comb begin
        dec_item.ev.ev_time  = i_cmd.event_time;
        dec_item.ev.ev_name  = i_cmd.event_name;
        dec_item.ev.ev_task  = i_cmd.event_task;
        dec_item.ev.ev_break = i_cmd.event_break;
        dec_item.position    = i_cmd.position;
        unique case (i_cmd.cmd)
            CMD_INSERT: dec_item.op = OP_INSERT;
            CMD_POP:    dec_item.op = OP_POP;
            CMD_REMOVE: dec_item.op = OP_REMOVE;
            default:    dec_item.op = OP_NOP;
        endcase
    end

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_item    = r_q[r_rd];

    always_comb begin
        n_wr  = r_wr ^ push;
        n_rd  = r_rd ^ i_q_pop;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec_item;
        end
    end

endmodule

>>> sv/toeq_back.sv
// Execution back end: sorted row of event cells and the result register.
module toeq_back #(
    parameter int CAPACITY = toeq_pkg::DEF_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  toeq_pkg::t_cmd_item  i_q_item,
    output logic                 o_q_pop,
    toeq_res_if.source           o_res
);
    import toeq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    t_event               r_slot [CAPACITY];
    t_event               n_slot [CAPACITY];
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_out_valid, n_out_valid;
    t_result              r_res, n_res;
    logic                 take;
    logic [CAPACITY-1:0]  above;
    logic [CAPACITY-1:0]  above_prev;
    logic [POS_W-1:0]     rm_pos;
    logic [IDX_W-1:0]     rm_idx;

    // Cells holding a time not below the new one; monotonic over the occupied part
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            above[k] = (CNT_W'(k) < r_count) && (r_slot[k].ev_time >= i_q_item.ev.ev_time);
        end
        above_prev = {above[CAPACITY-2:0], 1'b0};
    end

    assign take   = i_q_valid && (!r_out_valid || o_res.ready);
    assign rm_pos = (i_q_item.op == OP_POP) ? '0 : i_q_item.position;
    assign rm_idx = rm_pos[IDX_W-1:0];

    always_comb begin
        n_slot      = r_slot;
        n_count     = r_count;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_res.ready;
        if (take) begin
            n_out_valid  = 1'b1;
            n_res.status = ST_OK;
            n_res.ev     = '0;
            unique case (i_q_item.op)
                OP_INSERT: begin
                    if (r_count == CNT_W'(CAPACITY)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        for (int k = 0; k < CAPACITY; k++) begin
                            if (above_prev[k]) begin
                                n_slot[k] = r_slot[(k > 0) ? k - 1 : 0];
                            end else if (above[k] || CNT_W'(k) == r_count) begin
                                n_slot[k] = i_q_item.ev;
                            end
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_POP, OP_REMOVE: begin
                    if (r_count == '0) begin
                        n_res.status = ST_EMPTY;
                    end else if (32'(rm_pos) >= 32'(r_count)) begin
                        n_res.status = ST_RANGE;
                    end else begin
                        n_res.ev = r_slot[rm_idx];
                        for (int k = 0; k < CAPACITY - 1; k++) begin
                            if (k >= int'(rm_pos)) begin
                                n_slot[k] = r_slot[k + 1];
                            end
                        end
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_NOP: begin
                end
            endcase
            n_res.occupancy = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_res  <= n_res;
    end

    assign o_q_pop         = take;
    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_res.status;
    assign o_res.out_time  = r_res.ev.ev_time;
    assign o_res.out_name  = r_res.ev.ev_name;
    assign o_res.out_task  = r_res.ev.ev_task;
    assign o_res.out_break = r_res.ev.ev_break;
    assign o_res.occupancy = r_res.occupancy;

endmodule

>>> sv/time_ordered_event_queue_core.sv
// Time-ordered event queue: a bounded list of events kept sorted by time. Insert places
// an event ahead of every stored event with an equal or later time; pop takes out the
// earliest; remove takes out the event at a zero-based position. Every command returns
// one result with status, the event taken out (zeros if none) and the count afterward.
// Commands are decoded into a two-entry queue; the back end runs one command per cycle,
// while no result waits on the output, on a row of CAPACITY event cells that all compare
// against the new time at once, so the sustained rate is one command per cycle. A command
// waits in the queue until the back end takes it, and its result is then registered. A
// result left waiting on the output stalls the back end, and the input stalls once the
// queue holds two commands. The cell compare row sets the clock period.
`include "time_ordered_event_queue_core_assert.svh"

module time_ordered_event_queue_core #(
    parameter int CAPACITY = toeq_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    toeq_cmd_if.sink    i_cmd,
    toeq_res_if.source  o_res
);
    import toeq_pkg::*;

    logic      q_valid;
    t_cmd_item q_item;
    logic      q_pop;
    logic      res_err;
    logic      res_has_ev;
    logic      res_full;
    logic      res_empty;
    logic      occ_full;

    toeq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    toeq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

    assign res_err    = o_res.valid && (o_res.status != ST_OK);
    assign res_has_ev = (o_res.out_time != '0) || (o_res.out_name != '0) ||
                        (o_res.out_task != '0) || o_res.out_break;
    assign res_full   = o_res.valid && (o_res.status == ST_FULL);
    assign res_empty  = o_res.valid && (o_res.status == ST_EMPTY);
    assign occ_full   = (o_res.occupancy == OCC_W'(CAPACITY));

    `TOEQ_CHECK(a_pop_needs_item, i_clk, i_rst_n, !q_pop || q_valid, "pop from empty cmd queue")
    `TOEQ_IMPLY(a_err_zero_out, i_clk, i_rst_n, res_err, !res_has_ev, "error result with event")
    `TOEQ_IMPLY(a_full_count, i_clk, i_rst_n, res_full, occ_full, "full status with room left")
    `TOEQ_IMPLY(a_empty_count, i_clk, i_rst_n, res_empty, o_res.occupancy == '0, "empty but stored")

endmodule

>>> tb/time_ordered_event_queue_core_tb.sv
// Self-checking testbench for the time-ordered event queue core.
`timescale 1ns / 1ps

module time_ordered_event_queue_core_tb;
    import toeq_pkg::*;

    localparam int          CAPACITY     = DEF_CAPACITY;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int          RANDOM_ITEMS = 1650;
    localparam int          HOLD_AT      = 400;     // result count at which the sink holds off
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    // Mirror of the sorted event store; holds the results still owed by the block.
    class event_queue_mirror;
        t_event      slots [CAPACITY];
        int unsigned count = 0;
        t_result     owed_results[$];
        int unsigned mismatches = 0;

        function t_event take_out(int unsigned idx);
            t_event ev;
            ev = slots[idx];
            for (int unsigned k = idx; k + 1 < count; k++) begin
                slots[k] = slots[k + 1];
            end
            count--;
            return ev;
        endfunction

        function void note_command(logic [1:0] cmd, t_event ev, logic [POS_W-1:0] pos);
            t_result     res;
            int unsigned idx;
            res = '0;
            res.status = ST_OK;
            case (cmd)
                CMD_INSERT: begin
                    if (count >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        // newest goes ahead of equal times
                        idx = 0;
                        while (idx < count && slots[idx].ev_time < ev.ev_time) idx++;
                        for (int unsigned k = count; k > idx; k--) begin
                            slots[k] = slots[k - 1];
                        end
                        slots[idx] = ev;
                        count++;
                    end
                end
                CMD_POP: begin
                    if (count == 0) res.status = ST_EMPTY;
                    else res.ev = take_out(0);
                end
                CMD_REMOVE: begin
                    if (count == 0) res.status = ST_EMPTY;
                    else if (pos >= count) res.status = ST_RANGE;
                    else res.ev = take_out(pos);
                end
                default: ;
            endcase
            res.occupancy = count[OCC_W-1:0];
            owed_results.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $error("result with no command outstanding");
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.ev.ev_time !== want.ev.ev_time) begin
                $error("out_time: expected %0h, got %0h", want.ev.ev_time, got.ev.ev_time);
                mismatches++;
            end
            if (got.ev.ev_name !== want.ev.ev_name) begin
                $error("out_name: expected %0h, got %0h", want.ev.ev_name, got.ev.ev_name);
                mismatches++;
            end
            if (got.ev.ev_task !== want.ev.ev_task) begin
                $error("out_task: expected %0h, got %0h", want.ev.ev_task, got.ev.ev_task);
                mismatches++;
            end
            if (got.ev.ev_break !== want.ev.ev_break) begin
                $error("out_break: expected %0b, got %0b", want.ev.ev_break, got.ev.ev_break);
                mismatches++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    toeq_cmd_if cmd_if ();
    toeq_res_if res_if ();

    event_queue_mirror mirror = new;
    int                send_mode = 0;
    int unsigned       cycles = 0;

    time_ordered_event_queue_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // 0: never idle, 1: a random idle gap before every item, 2: mostly busy with occasional gaps
    function automatic int draw_gap(int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, 19);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
    endfunction

    task automatic send_command(logic [1:0] cmd, t_event ev, logic [POS_W-1:0] pos);
        int gap;
        gap = draw_gap(send_mode);
        if (gap > 0) begin
            @(negedge i_clk) cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_if.valid       <= 1'b1;
        cmd_if.cmd         <= cmd;
        cmd_if.event_time  <= ev.ev_time;
        cmd_if.event_name  <= ev.ev_name;
        cmd_if.event_task  <= ev.ev_task;
        cmd_if.event_break <= ev.ev_break;
        cmd_if.position    <= pos;
        do @(posedge i_clk); while (!cmd_if.ready);
        mirror.note_command(cmd, ev, pos);
    endtask

    task automatic send_insert(logic [TIME_W-1:0] t, logic [NAME_W-1:0] nm,
                               logic [TASK_W-1:0] tsk, logic brk);
        t_event ev;
        ev = '{ev_time: t, ev_name: nm, ev_task: tsk, ev_break: brk};
        send_command(CMD_INSERT, ev, '0);
    endtask

    function automatic t_event random_event();
        t_event ev;
        int     sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            ev.ev_time = $urandom_range(0, 15);     // dense times give many ties
        end else if (sel < 40) begin
            case ($urandom_range(0, 3))
                0: ev.ev_time = '0;
                1: ev.ev_time = '1;
                2: ev.ev_time = 32'h7FFF_FFFF;
                default: ev.ev_time = 32'h8000_0000;
            endcase
        end else begin
            ev.ev_time = $urandom;
        end
        ev.ev_name  = NAME_W'($urandom_range(0, 255));
        ev.ev_task  = TASK_W'($urandom_range(0, 255));
        ev.ev_break = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    function automatic logic [POS_W-1:0] random_position(int unsigned count);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70 && count > 0) return POS_W'($urandom_range(0, count - 1));
        if (sel < 85) return POS_W'(count + $urandom_range(0, 2));
        return POS_W'($urandom_range(0, 255));
    endfunction

    task automatic run_directed();
        t_event none;
        none = '0;
        send_command(CMD_POP, none, '0);
        send_command(CMD_REMOVE, none, 8'd0);
        send_command(CMD_REMOVE, none, 8'd255);
        send_command(CMD_UNUSED, random_event(), 8'd255);
        send_insert(32'd100, 8'h41, 8'h00, 1'b0);
        send_insert(32'd100, 8'h42, 8'hFF, 1'b1);      // tie: lands ahead of the first
        send_insert(32'd0, 8'h00, 8'hFF, 1'b0);
        send_insert(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
        send_insert(32'd50, 8'h55, 8'hAA, 1'b1);
        send_insert(32'h8000_0000, 8'hAA, 8'h55, 1'b0); // unsigned compare around the top bit
        send_insert(32'h7FFF_FFFF, 8'h7F, 8'h80, 1'b1);
        send_command(CMD_UNUSED, random_event(), POS_W'($urandom_range(0, 255)));
        send_command(CMD_REMOVE, none, 8'd7);           // one past the end
        send_command(CMD_REMOVE, none, 8'd255);
        send_command(CMD_REMOVE, none, 8'd6);           // last entry
        send_command(CMD_REMOVE, none, 8'd2);
        send_command(CMD_REMOVE, none, 8'd0);
        repeat (5) send_command(CMD_POP, none, '0);
    endtask

    task automatic run_random();
        int     sent;
        int     burst;
        int     phase;
        int     roll;
        t_event ev;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst     = $urandom_range(20, 80);
            phase     = $urandom_range(0, 2);   // 0 filling, 1 draining, 2 mixed
            send_mode = $urandom_range(0, 2);
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                ev   = random_event();
                if (roll < 2) begin
                    send_command(CMD_UNUSED, ev, POS_W'($urandom_range(0, 255)));
                end else if ((phase == 0 && roll < 77) || (phase == 1 && roll < 22) ||
                             (phase == 2 && roll < 47)) begin
                    send_command(CMD_INSERT, ev, POS_W'($urandom_range(0, 255)));
                end else if ((phase == 0 && roll < 87) || (phase == 1 && roll < 57) ||
                             (phase == 2 && roll < 72)) begin
                    send_command(CMD_POP, ev, POS_W'($urandom_range(0, 255)));
                end else begin
                    send_command(CMD_REMOVE, ev, random_position(mirror.count));
                end
                sent++;
            end
        end
    endtask

    // result sink with its own idle pattern and one long hold-off
    initial begin
        int          stall;
        int          rcv_mode;
        int unsigned seen;
        t_result     got;
        seen         = 0;
        rcv_mode     = 0;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (seen % 50 == 0) rcv_mode = $urandom_range(0, 2);
            stall = (seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(rcv_mode);
            if (stall > 0) begin
                @(negedge i_clk) res_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            got.status       = t_status'(res_if.status);
            got.ev.ev_time   = res_if.out_time;
            got.ev.ev_name   = res_if.out_name;
            got.ev.ev_task   = res_if.out_task;
            got.ev.ev_break  = res_if.out_break;
            got.occupancy    = res_if.occupancy;
            mirror.check_result(got);
            seen++;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.cmd         = CMD_INSERT;
        cmd_if.event_time  = '0;
        cmd_if.event_name  = '0;
        cmd_if.event_task  = '0;
        cmd_if.event_break = 1'b0;
        cmd_if.position    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();
        @(negedge i_clk) cmd_if.valid <= 1'b0;

        while (mirror.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mirror.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
